### design/ffha_pkg.sv
`default_nettype none
package ffha_pkg;

	localparam int OFF_W = 17;

	localparam int ALIGN_BYTES = 8;

	localparam logic [1:0] REG_HEAP_LIMIT = 2'd0;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_ZERO  = 2'd1;
	localparam logic [1:0] ST_OOM   = 2'd2;
	localparam logic [1:0] ST_DFREE = 2'd3;

	localparam logic [16:0] HEAP_LIMIT_RST = 17'd65536;

	typedef struct packed {
		logic        opcode;
		logic [16:0] request_bytes;
		logic [15:0] release_addr;
	} req_t;

	typedef struct packed {
		logic [15:0] payload_addr;
		logic [1:0]  status;
	} rsp_t;

	typedef struct packed {
		logic [OFF_W-1:0] size;
		logic [OFF_W-1:0] prev;
		logic             free;
		logic             start;
		logic             hasprev;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage
`default_nettype wire

### design/ffha_ram.sv
`default_nettype none
module ffha_ram #(
	parameter int WIDTH = 37,
	parameter int DEPTH = 8192
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule
`default_nettype wire

### design/ffha_ctrl.sv
`default_nettype none
module ffha_ctrl
	import ffha_pkg::*;
#(
	parameter int HEAP_BYTES   = 65536,
	parameter int HEADER_BYTES = 32,
	localparam int SPAN  = (HEAP_BYTES < 65536) ? HEAP_BYTES : 65536,
	localparam int DEPTH = SPAN / ALIGN_BYTES,
	localparam int AW    = $clog2(DEPTH)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [16:0]   heap_limit,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire req_t          in_data,
	output logic               out_valid,
	input  wire logic          out_ready,
	output rsp_t               out_data,
	output logic               ram_we,
	output logic [AW-1:0]      ram_addr,
	output logic [ENTRY_W-1:0] ram_wdata,
	input  wire logic [ENTRY_W-1:0] ram_rdata
);

	localparam int ALB = $clog2(ALIGN_BYTES);
	localparam int SW  = OFF_W + 2;
	localparam int HDR = ((HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
	localparam logic [SW-1:0] HDR_W   = SW'(HDR);
	localparam logic [SW-1:0] SPLIT_W = SW'(HDR + ALIGN_BYTES);
	localparam logic [SW-1:0] SPAN_W  = SW'(SPAN);

	typedef enum logic [3:0] {
		S_IDLE, S_WALK_RD, S_WALK_CHK, S_SPLIT, S_APPEND, S_FIX_RD, S_FIX_WR,
		S_FINAL_WR, S_FREE_RD, S_FREE_CHK, S_PREV_RD, S_PREV_CHK, S_NEXT_RD,
		S_NEXT_CHK
	} state_t;

	state_t           state_q, ret_q;
	logic [OFF_W-1:0] need_q, cur_q, last_q, top_q, aux_q, fix_addr_q, fix_val_q;
	logic [15:0]      res_addr_q;
	entry_t           ent_q;
	logic             out_valid_q;
	rsp_t             out_q;

	entry_t           rd_e, wr_e;
	logic [SW-1:0]    limit_w, need_w, rel_w, cur_end, split_rest, sum_a;

	function automatic logic [AW-1:0] slot(input logic [OFF_W-1:0] off);
		slot = off[ALB +: AW];
	endfunction

	assign rd_e       = entry_t'(ram_rdata);
	assign ram_wdata  = ENTRY_W'(wr_e);
	assign in_ready   = (state_q == S_IDLE) && !out_valid_q;
	assign out_valid  = out_valid_q;
	assign out_data   = out_q;
	assign limit_w    = (SW'(heap_limit) < SPAN_W) ? SW'(heap_limit) : SPAN_W;
	assign need_w     = (SW'(in_data.request_bytes) + SW'(ALIGN_BYTES - 1)) &
	                    ~SW'(ALIGN_BYTES - 1);
	assign rel_w      = SW'(in_data.release_addr);
	assign cur_end    = SW'(cur_q) + HDR_W + SW'(ent_q.size);
	assign split_rest = SW'(rd_e.size) - SW'(need_q);
	assign sum_a      = SW'(top_q) + HDR_W + SW'(need_q);

	always_comb begin
		ram_we   = 1'b0;
		ram_addr = slot(cur_q);
		wr_e     = ent_q;
		case (state_q)
			S_WALK_RD, S_FREE_RD: ram_addr = slot(cur_q);
			S_SPLIT: begin
				ram_we       = 1'b1;
				ram_addr     = slot(OFF_W'(SW'(cur_q) + HDR_W + SW'(need_q)));
				wr_e.size    = OFF_W'(SW'(ent_q.size) - SW'(need_q) - HDR_W);
				wr_e.prev    = cur_q;
				wr_e.free    = 1'b1;
				wr_e.start   = 1'b1;
				wr_e.hasprev = 1'b1;
			end
			S_APPEND: begin
				ram_we       = (sum_a <= limit_w);
				ram_addr     = slot(top_q);
				wr_e.size    = need_q;
				wr_e.prev    = last_q;
				wr_e.free    = 1'b0;
				wr_e.start   = 1'b1;
				wr_e.hasprev = (top_q != '0);
			end
			S_FIX_RD: ram_addr = slot(fix_addr_q);
			S_FIX_WR: begin
				ram_we    = 1'b1;
				ram_addr  = slot(fix_addr_q);
				wr_e      = rd_e;
				wr_e.prev = fix_val_q;
			end
			S_FINAL_WR: ram_we = 1'b1;
			S_PREV_RD: ram_addr = slot(ent_q.prev);
			S_PREV_CHK: begin
				ram_we = rd_e.free;
				wr_e   = '0;
			end
			S_NEXT_RD: ram_addr = slot(OFF_W'(cur_end));
			S_NEXT_CHK: begin
				ram_we   = rd_e.free;
				ram_addr = slot(aux_q);
				wr_e     = '0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ret_q       <= S_IDLE;
			top_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						if (in_data.opcode == OP_ALLOC) begin
							need_q     <= OFF_W'(need_w);
							cur_q      <= '0;
							last_q     <= '0;
							if (in_data.request_bytes == '0) begin
								out_valid_q <= 1'b1;
								out_q       <= '{payload_addr: '0, status: ST_ZERO};
							end else if (need_w > SPAN_W) begin
								out_valid_q <= 1'b1;
								out_q       <= '{payload_addr: '0, status: ST_OOM};
							end else begin
								state_q <= S_WALK_RD;
							end
						end else begin
							res_addr_q <= '0;
							cur_q      <= OFF_W'(rel_w - HDR_W);
							if (rel_w == '0) begin
								out_valid_q <= 1'b1;
								out_q       <= '{payload_addr: '0, status: ST_OK};
							end else if (rel_w < HDR_W ||
							             in_data.release_addr[ALB-1:0] != '0 ||
							             rel_w - HDR_W >= SW'(top_q)) begin
								out_valid_q <= 1'b1;
								out_q       <= '{payload_addr: '0, status: ST_DFREE};
							end else begin
								state_q <= S_FREE_RD;
							end
						end
					end
				end
				S_WALK_RD: begin
					state_q <= (cur_q < top_q) ? S_WALK_CHK : S_APPEND;
				end
				S_WALK_CHK: begin
					if (rd_e.free && rd_e.size >= need_q) begin
						ent_q      <= '{size: rd_e.size, prev: rd_e.prev, free: 1'b0,
						                start: rd_e.start, hasprev: rd_e.hasprev};
						res_addr_q <= 16'(SW'(cur_q) + HDR_W);
						state_q    <= (split_rest >= SPLIT_W) ? S_SPLIT : S_FINAL_WR;
					end else begin
						last_q  <= cur_q;
						cur_q   <= OFF_W'(SW'(cur_q) + HDR_W + SW'(rd_e.size));
						state_q <= S_WALK_RD;
					end
				end
				S_SPLIT: begin
					ent_q.size <= need_q;
					fix_addr_q <= OFF_W'(cur_end);
					fix_val_q  <= OFF_W'(SW'(cur_q) + HDR_W + SW'(need_q));
					ret_q      <= S_FINAL_WR;
					state_q    <= (cur_end < SW'(top_q)) ? S_FIX_RD : S_FINAL_WR;
				end
				S_APPEND: begin
					out_valid_q <= 1'b1;
					if (sum_a > limit_w) begin
						out_q <= '{payload_addr: '0, status: ST_OOM};
					end else begin
						out_q <= '{payload_addr: 16'(SW'(top_q) + HDR_W), status: ST_OK};
						top_q <= OFF_W'(sum_a);
					end
					state_q <= S_IDLE;
				end
				S_FIX_RD: state_q <= S_FIX_WR;
				S_FIX_WR: state_q <= ret_q;
				S_FINAL_WR: begin
					out_valid_q <= 1'b1;
					out_q       <= '{payload_addr: res_addr_q, status: ST_OK};
					state_q     <= S_IDLE;
				end
				S_FREE_RD: state_q <= S_FREE_CHK;
				S_FREE_CHK: begin
					if (!rd_e.start || rd_e.free) begin
						out_valid_q <= 1'b1;
						out_q       <= '{payload_addr: '0, status: ST_DFREE};
						state_q     <= S_IDLE;
					end else begin
						ent_q   <= '{size: rd_e.size, prev: rd_e.prev, free: 1'b1,
						             start: rd_e.start, hasprev: rd_e.hasprev};
						state_q <= rd_e.hasprev ? S_PREV_RD : S_NEXT_RD;
					end
				end
				S_PREV_RD: state_q <= S_PREV_CHK;
				S_PREV_CHK: begin
					if (rd_e.free) begin
						ent_q      <= '{size: OFF_W'(SW'(rd_e.size) + HDR_W + SW'(ent_q.size)),
						                prev: rd_e.prev, free: rd_e.free,
						                start: rd_e.start, hasprev: rd_e.hasprev};
						cur_q      <= ent_q.prev;
						fix_addr_q <= OFF_W'(cur_end);
						fix_val_q  <= ent_q.prev;
						ret_q      <= S_NEXT_RD;
						state_q    <= (cur_end < SW'(top_q)) ? S_FIX_RD : S_NEXT_RD;
					end else begin
						state_q <= S_NEXT_RD;
					end
				end
				S_NEXT_RD: begin
					aux_q   <= OFF_W'(cur_end);
					state_q <= (cur_end < SW'(top_q)) ? S_NEXT_CHK : S_FINAL_WR;
				end
				S_NEXT_CHK: begin
					if (rd_e.free) begin
						ent_q.size <= OFF_W'(SW'(ent_q.size) + HDR_W + SW'(rd_e.size));
						fix_addr_q <= OFF_W'(cur_end + HDR_W + SW'(rd_e.size));
						fix_val_q  <= cur_q;
						ret_q      <= S_FINAL_WR;
						state_q    <= (cur_end + HDR_W + SW'(rd_e.size) < SW'(top_q)) ?
						              S_FIX_RD : S_FINAL_WR;
					end else begin
						state_q <= S_FINAL_WR;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

### design/first_fit_heap_allocator.sv
// Channel   Direction  Payload  Handshake
// in        input      req_t    in_valid / in_ready
// out       output     rsp_t    out_valid / out_ready
// apb       input      heap_limit at paddr 0
//
// An allocate request walks the headers in order through the single memory port, then appends
// at the heap top or takes the first free block that fits; a zero or oversized size is answered
// without a walk. A free request merges with a free previous and then a free next neighbor; a
// null or malformed release answers without a memory read and a double free after its header read.
// The header memory is not cleared at reset; only the heap top, heap limit and control state are.
// A finished result waits in the output register and the next request is taken once it leaves.
`default_nettype none
module first_fit_heap_allocator
	import ffha_pkg::*;
#(
	parameter int HEAP_BYTES   = 65536,
	parameter int HEADER_BYTES = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [1:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire req_t        in_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output rsp_t             out_data
);

	localparam int SPAN  = (HEAP_BYTES < 65536) ? HEAP_BYTES : 65536;
	localparam int DEPTH = SPAN / ALIGN_BYTES;
	localparam int AW    = $clog2(DEPTH);

	logic [16:0]        heap_limit_q;
	logic               ram_we;
	logic [AW-1:0]      ram_addr;
	logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

	assign pready = 1'b1;
	assign prdata = {15'd0, heap_limit_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_limit_q <= HEAP_LIMIT_RST;
		end else if (psel && penable && pwrite && paddr == REG_HEAP_LIMIT) begin
			heap_limit_q <= pwdata[16:0];
		end
	end

	ffha_ctrl #(
		.HEAP_BYTES  (HEAP_BYTES),
		.HEADER_BYTES(HEADER_BYTES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.heap_limit(heap_limit_q),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.ram_we    (ram_we),
		.ram_addr  (ram_addr),
		.ram_wdata (ram_wdata),
		.ram_rdata (ram_rdata)
	);

	ffha_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

endmodule
`default_nettype wire

### dv/tb_first_fit_heap_allocator.sv
`default_nettype none
module tb_first_fit_heap_allocator;
	import ffha_pkg::*;

	localparam int unsigned HDR = 32;
	localparam int unsigned ALN = 8;
	localparam int unsigned SLOTS = 8192;
	localparam int unsigned SPAN = 65536;
	localparam int STALL_LIMIT = 60000;

	class heap_scoreboard;
		bit [16:0] hsize[SLOTS];
		bit [16:0] hprev[SLOTS];
		bit hfree[SLOTS];
		bit hstart[SLOTS];
		bit hhas[SLOTS];
		bit [16:0] heap_top;
		bit [16:0] heap_limit;
		rsp_t pending[$];
		logic [15:0] live[$];
		logic [15:0] retired[$];
		logic [15:0] last_addr;
		int errors;
		int n_alloc_ok, n_zero, n_oom, n_bad, n_free_ok;

		function new();
			heap_top = 0;
			heap_limit = 17'd65536;
		endfunction

		function int unsigned slot_of(int unsigned off);
			return (off / ALN < SLOTS) ? off / ALN : 0;
		endfunction

		function logic [1:0] grant(int unsigned req, output logic [15:0] addr);
			int unsigned need, lim, cur, prior, n, i, sp, j, nx;
			bit found;
			cur = 0; prior = 0; n = 0; i = 0; found = 0;
			addr = 0;
			if (req == 0)
				return ST_ZERO;
			need = ((req + ALN - 1) / ALN) * ALN;
			lim = heap_limit;
			if (lim > SPAN)
				lim = SPAN;
			while (cur < heap_top && n < SLOTS) begin
				i = slot_of(cur);
				if (hfree[i] && hsize[i] >= need) begin
					found = 1;
					break;
				end
				prior = cur;
				cur += HDR + hsize[i];
				n++;
			end
			if (found) begin
				if (hsize[i] - need >= HDR + ALN) begin
					sp = cur + HDR + need;
					j = slot_of(sp);
					hsize[j] = 17'(hsize[i] - need - HDR);
					hprev[j] = 17'(cur);
					hfree[j] = 1; hstart[j] = 1; hhas[j] = 1;
					nx = sp + HDR + hsize[j];
					if (nx < heap_top)
						hprev[slot_of(nx)] = 17'(sp);
					hsize[i] = 17'(need);
				end
				hfree[i] = 0;
				addr = 16'(cur + HDR);
				return ST_OK;
			end
			if (heap_top + HDR + need > lim)
				return ST_OOM;
			i = slot_of(heap_top);
			hsize[i] = 17'(need);
			hprev[i] = 17'(prior);
			hfree[i] = 0; hstart[i] = 1; hhas[i] = (heap_top != 0);
			addr = 16'(heap_top + HDR);
			heap_top = 17'(heap_top + HDR + need);
			return ST_OK;
		endfunction

		function logic [1:0] release_block(int unsigned a);
			int unsigned b, i, nx, p, k, m, nn;
			if (a == 0)
				return ST_OK;
			if (a < HDR)
				return ST_DFREE;
			b = a - HDR;
			if (b % ALN != 0 || b >= heap_top)
				return ST_DFREE;
			i = slot_of(b);
			if (!hstart[i] || hfree[i])
				return ST_DFREE;
			hfree[i] = 1;
			if (hhas[i]) begin
				p = hprev[i];
				k = slot_of(p);
				if (hfree[k]) begin
					nx = b + HDR + hsize[i];
					hsize[k] = 17'(hsize[k] + HDR + hsize[i]);
					hfree[i] = 0; hstart[i] = 0; hhas[i] = 0;
					if (nx < heap_top)
						hprev[slot_of(nx)] = 17'(p);
					b = p;
					i = k;
				end
			end
			nx = b + HDR + hsize[i];
			if (nx < heap_top) begin
				m = slot_of(nx);
				if (hfree[m]) begin
					hsize[i] = 17'(hsize[i] + HDR + hsize[m]);
					hfree[m] = 0; hstart[m] = 0; hhas[m] = 0;
					nn = b + HDR + hsize[i];
					if (nn < heap_top)
						hprev[slot_of(nn)] = 17'(b);
				end
			end
			return ST_OK;
		endfunction

		function void note(req_t r);
			rsp_t e;
			logic [15:0] a;
			if (r.opcode == OP_ALLOC) begin
				e.status = grant(32'(r.request_bytes), a);
				e.payload_addr = a;
				last_addr = a;
				if (e.status == ST_OK) begin
					live.push_back(a);
					n_alloc_ok++;
				end else if (e.status == ST_ZERO)
					n_zero++;
				else
					n_oom++;
			end else begin
				e.status = release_block(32'(r.release_addr));
				e.payload_addr = 0;
				if (e.status == ST_OK && r.release_addr != 0) begin
					n_free_ok++;
					if (retired.size() < 64)
						retired.push_back(r.release_addr);
				end else if (e.status == ST_DFREE)
					n_bad++;
			end
			pending.push_back(e);
		endfunction

		function void check(rsp_t got);
			rsp_t e;
			if (pending.size() == 0) begin
				$error("unexpected result: payload_addr %0d status %0d",
					got.payload_addr, got.status);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.payload_addr !== e.payload_addr) begin
				$error("payload_addr mismatch: expected %0d, actual %0d",
					e.payload_addr, got.payload_addr);
				errors++;
			end
			if (got.status !== e.status) begin
				$error("status mismatch: expected %0d, actual %0d", e.status, got.status);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 0;
	logic in_ready;
	req_t in_data = '0;
	logic out_valid;
	logic out_ready = 0;
	rsp_t out_data;

	heap_scoreboard sb = new();
	int burst_left = 0;
	int quiet = 0;
	bit hold_req = 0;
	int stall_left = 0, run_left = 0;

	always #5 clk = ~clk;

	first_fit_heap_allocator u_top (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	always @(negedge clk) begin
		if (out_valid && out_ready)
			sb.check(out_data);
		if ((in_valid && in_ready) || (out_valid && out_ready) || psel || !arst_n)
			quiet = 0;
		else
			quiet++;
		if (quiet >= STALL_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (hold_req) begin
			hold_req = 0;
			stall_left = 400;
		end
		if (stall_left > 0) begin
			out_ready <= 0;
			stall_left--;
		end else if (run_left > 0) begin
			out_ready <= 1;
			run_left--;
		end else begin
			out_ready <= 1;
			run_left = $urandom_range(0, 30);
			stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
		end
	end

	task automatic write_limit(logic [16:0] v);
		psel <= 1; pwrite <= 1; penable <= 0; paddr <= REG_HEAP_LIMIT; pwdata <= {15'd0, v};
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		sb.heap_limit = v;
		@(posedge clk);
	endtask

	task automatic send(logic op, logic [16:0] bytes, logic [15:0] addr);
		req_t r;
		bit ok;
		r.opcode = op; r.request_bytes = bytes; r.release_addr = addr;
		if (burst_left == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
			burst_left = $urandom_range(1, 20);
		end
		in_valid <= 1;
		in_data <= r;
		do begin
			@(negedge clk);
			ok = in_ready;
			@(posedge clk);
		end while (!ok);
		burst_left--;
		sb.note(r);
	endtask

	task automatic drain();
		in_valid <= 0;
		burst_left = 0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic random_item();
		int unsigned k, lo;
		logic [15:0] a;
		k = $urandom_range(0, 99);
		if (k < 55) begin
			k = $urandom_range(0, 99);
			if (k < 85)
				send(OP_ALLOC, 17'($urandom_range(1, 600)), 16'($urandom));
			else if (k < 93)
				send(OP_ALLOC, 17'($urandom_range(601, 4096)), 16'($urandom));
			else if (k < 97)
				send(OP_ALLOC, 17'd0, 16'($urandom));
			else
				send(OP_ALLOC, 17'($urandom_range(4097, 131071)), 16'($urandom));
			return;
		end
		k = $urandom_range(0, 99);
		if (k < 78 && sb.live.size() > 0) begin
			lo = $urandom_range(0, sb.live.size() - 1);
			a = sb.live[lo];
			sb.live.delete(lo);
		end else if (k < 86 && sb.retired.size() > 0) begin
			a = sb.retired[$urandom_range(0, sb.retired.size() - 1)];
		end else if (k < 90) begin
			a = 0;
		end else if (k < 93) begin
			a = 16'($urandom_range(1, HDR - 1));
		end else if (k < 96) begin
			a = 16'(($urandom_range(HDR, 65535) & 32'hfff8) | $urandom_range(1, 7));
		end else if (sb.heap_top + HDR <= 65535) begin
			a = 16'($urandom_range(sb.heap_top + HDR, 65535));
		end else begin
			a = 0;
		end
		send(OP_FREE, 17'($urandom), a);
	endtask

	initial begin
		logic [15:0] b1, b2, b3, b4;
		arst_n = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		write_limit(17'd65536);

		send(OP_ALLOC, 0, 16'hffff);
		send(OP_ALLOC, 1, 0); b1 = sb.last_addr;
		send(OP_ALLOC, 100, 0); b2 = sb.last_addr;
		send(OP_ALLOC, 100, 0); b3 = sb.last_addr;
		send(OP_ALLOC, 200, 0); b4 = sb.last_addr;
		send(OP_ALLOC, 8, 0);
		send(OP_ALLOC, 17'd65536, 0);
		send(OP_ALLOC, 17'h1ffff, 0);
		send(OP_FREE, 17'h1ffff, 0);
		send(OP_FREE, 0, 8);
		send(OP_FREE, 0, 33);
		send(OP_FREE, 0, 16'hffff);
		send(OP_FREE, 0, b1);
		send(OP_FREE, 0, b3);
		send(OP_FREE, 0, b2);
		send(OP_FREE, 0, b2);
		send(OP_FREE, 0, b3);
		send(OP_ALLOC, 40, 0);
		send(OP_FREE, 0, b4);
		send(OP_FREE, 0, b4);
		send(OP_ALLOC, 600, 0);
		sb.live.delete();
		drain();

		repeat (300) random_item();
		drain();
		write_limit(17'h1ffff);
		repeat (150) random_item();
		drain();
		write_limit(17'd0);
		repeat (60) random_item();
		drain();
		write_limit(17'($urandom_range(2000, 20000)));
		repeat (60) random_item();
		hold_req = 1;
		repeat (80) random_item();
		drain();
		repeat (60) random_item();
		drain();
		write_limit(17'd65536);
		repeat (140) random_item();
		drain();

		$display("Covered %0d grants, %0d frees, %0d zero-size, %0d out-of-memory,",
			sb.n_alloc_ok, sb.n_free_ok, sb.n_zero, sb.n_oom);
		$display("and %0d rejected releases over four heap limit settings.", sb.n_bad);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
`default_nettype wire
